[sv/integer_square_root_rounded_top_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the square root block.
// ---------------------------------------------------------------------------
`ifndef INTEGER_SQUARE_ROOT_ROUNDED_TOP_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_ROUNDED_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ISR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/isr_pkg.sv]
// ---------------------------------------------------------------------------
// isr_pkg
// Types and constants shared by the square root pipeline.
// ---------------------------------------------------------------------------
package isr_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DIGIT_W = 2;

  // Working set carried down the digit pipeline.
  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] root;
    logic [WORD_W-1:0] value;
    logic              pass;
  } stage_t;

endpackage

[sv/integer_square_root_rounded_top.sv]
// ---------------------------------------------------------------------------
// integer_square_root_rounded_top
// Rounded integer square root of a signed 32-bit operand, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   Operands arrive on in_value with in_valid; a transfer happens at a clock
//   edge where in_valid is high and in_stall is low. Results leave on
//   out_root with out_valid and transfer when out_stall is low.
//   Operands of one or less, negative ones included, come back unchanged.
//   Each result passes one register per root digit, then a 32x32 squaring
//   stage, a subtract stage and the rounding/output register.
//   Throughput is one operand per cycle unless the receiver stalls; the digit
//   compare-subtract and the squaring multiplier each occupy their own stage.
//   When the receiver stalls a held result, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset (synchronous, active low) clears every valid bit; data in flight
//   is discarded. No result is pending after reset.
// ---------------------------------------------------------------------------
`include "integer_square_root_rounded_top_defines.svh"

module integer_square_root_rounded_top #(
  parameter int unsigned ROOT_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_root
);

  localparam int unsigned W = isr_pkg::WORD_W;

  logic                 en;
  logic [ROOT_STEPS:0]  vld;
  isr_pkg::stage_t      stg [ROOT_STEPS+1];
  logic [W-1:0]         raw;

  logic                 m_valid_r;
  logic [W-1:0]         m_root_r;
  logic [W-1:0]         m_sq_r;
  logic [W-1:0]         m_value_r;
  logic                 m_pass_r;

  logic                 d_valid_r;
  logic [W-1:0]         d_root_r;
  logic [W-1:0]         d_diff_r;
  logic [W-1:0]         d_rm1_r;
  logic [W-1:0]         d_value_r;
  logic                 d_pass_r;

  logic                 out_valid_r;
  logic [W-1:0]         out_root_r;
  logic [W-1:0]         out_root_nxt;

  // The pipeline advances unless a finished result is held by the receiver.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign raw = in_value;

  // Field order: rem, src, root, value, pass.
  assign stg[0] = {{W{1'b0}}, raw, {W{1'b0}}, raw,
                   raw[W-1] || (raw <= {{(W-1){1'b0}}, 1'b1})};
  assign vld[0] = in_valid;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    isr_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (vld[k]),
      .stage_i (stg[k]),
      .valid_o (vld[k+1]),
      .stage_o (stg[k+1])
    );
  end

  // Squaring stage; only the low word of the product is kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= vld[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_root_r  <= stg[ROOT_STEPS].root;
      m_sq_r    <= stg[ROOT_STEPS].root * stg[ROOT_STEPS].root;
      m_value_r <= stg[ROOT_STEPS].value;
      m_pass_r  <= stg[ROOT_STEPS].pass;
    end
  end

  // Residual and root minus one, both modulo 2^32.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_root_r  <= m_root_r;
      d_diff_r  <= m_value_r - m_sq_r;
      d_rm1_r   <= m_root_r - {{(W-1){1'b0}}, 1'b1};
      d_value_r <= m_value_r;
      d_pass_r  <= m_pass_r;
    end
  end

  always_comb begin
    if (d_pass_r) begin
      out_root_nxt = d_value_r;
    end else if (d_diff_r >= d_rm1_r) begin
      out_root_nxt = d_root_r + {{(W-1){1'b0}}, 1'b1};
    end else begin
      out_root_nxt = d_root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_root_r <= out_root_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_root  = $signed(out_root_r);

  `ISR_ASSERT_NEXT(a_sq_to_sub, en && m_valid_r, d_valid_r, "squared item lost before subtract")
  `ISR_ASSERT_NEXT(a_sub_to_out, en && d_valid_r, out_valid_r, "item lost before output")
  `ISR_ASSERT_NEXT(a_freeze_steps, !en, $stable(vld[ROOT_STEPS:1]), "digit stages moved in stall")
  `ISR_ASSERT_SAME(a_stall_only_full, in_stall, out_valid_r, "input stalled with no result held")

endmodule

[sv/isr_step.sv]
// ---------------------------------------------------------------------------
// isr_step
// One registered step of the restoring digit-by-digit square root: shifts two
// operand bits into the remainder, tries a subtract and sets one root bit.
// ---------------------------------------------------------------------------
module isr_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  isr_pkg::stage_t stage_i,
  output logic            valid_o,
  output isr_pkg::stage_t stage_o
);

  logic                           valid_r;
  isr_pkg::stage_t                stage_r;
  isr_pkg::stage_t                stage_nxt;
  logic [isr_pkg::WORD_W-1:0]     root_dbl;
  logic [isr_pkg::WORD_W-1:0]     rem_sh;
  logic [isr_pkg::WORD_W-1:0]     trial;

  always_comb begin
    root_dbl = {stage_i.root[isr_pkg::WORD_W-2:0], 1'b0};
    rem_sh   = {stage_i.rem[isr_pkg::WORD_W-isr_pkg::DIGIT_W-1:0],
                stage_i.src[isr_pkg::WORD_W-1 -: isr_pkg::DIGIT_W]};
    trial    = {root_dbl[isr_pkg::WORD_W-2:0], 1'b1};

    stage_nxt       = stage_i;
    stage_nxt.src   = {stage_i.src[isr_pkg::WORD_W-isr_pkg::DIGIT_W-1:0],
                       {isr_pkg::DIGIT_W{1'b0}}};
    stage_nxt.root  = root_dbl;
    stage_nxt.rem   = rem_sh;
    if (rem_sh >= trial) begin
      stage_nxt.root = root_dbl + {{(isr_pkg::WORD_W-1){1'b0}}, 1'b1};
      stage_nxt.rem  = rem_sh - trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

[sim/tb_integer_square_root_rounded_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_integer_square_root_rounded_top
// Self-checking bench for the pipelined rounded square root block. Directed
// edge operands come first, then a random mix of full-range, small,
// near-square and negative operands. Both channels idle and stall at random,
// and the receiver holds off once for long enough that the pipeline fills
// and stalls its input. Every result is compared with a bit-exact prediction.
// ---------------------------------------------------------------------------
module tb_integer_square_root_rounded_top;

  localparam int unsigned ROOT_STEPS = 16;
  localparam int          LATENCY    = ROOT_STEPS + 3;
  localparam int          RANDOM_OPS = 1450;
  localparam int          LONG_HOLD  = 100;

  class root_scoreboard;
    logic signed [31:0] expected_roots[$];
    int                 errors;

    function new();
      errors = 0;
    endfunction

    // Restoring digit-by-digit root with the block's own rounding rule.
    // All registers are 32 bits wide and wrap.
    static function logic [31:0] rounded_root(logic [31:0] operand);
      logic [31:0] rem;
      logic [31:0] src;
      logic [31:0] r;
      logic [31:0] trial;
      logic [31:0] diff;
      logic [31:0] r_minus_one;
      rem = '0;
      src = operand;
      r   = '0;
      for (int k = 0; k < ROOT_STEPS; k++) begin
        r     = r << 1;
        rem   = (rem << 2) | {30'd0, src[31:30]};
        src   = src << 2;
        trial = (r << 1) + 32'd1;
        if (rem >= trial) begin
          r   = r + 32'd1;
          rem = rem - trial;
        end
      end
      diff        = operand - r * r;
      r_minus_one = r - 32'd1;
      if (diff >= r_minus_one) r = r + 32'd1;
      return r;
    endfunction

    function void note_operand(logic signed [31:0] operand);
      // Negative operands, zero and one pass straight through.
      if (operand[31] || operand <= 32'sd1) expected_roots.push_back(operand);
      else expected_roots.push_back(rounded_root(operand));
    endfunction

    function void check_root(logic signed [31:0] root);
      logic signed [31:0] want;
      if (expected_roots.size() == 0) begin
        $error("root: unexpected result %0d with nothing pending", root);
        errors++;
        return;
      end
      want = expected_roots.pop_front();
      if (root !== want) begin
        $error("root mismatch: expected %0d, actual %0d", want, root);
        errors++;
      end
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction

    function void flag_leftovers();
      foreach (expected_roots[i]) begin
        $error("root: expected %0d never arrived", expected_roots[i]);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_root;

  root_scoreboard     sb = new();
  bit                 quiet;
  bit                 hold_request;

  integer_square_root_rounded_top #(
    .ROOT_STEPS(ROOT_STEPS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_root (out_root)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_integer_square_root_rounded_top: done, errors");
    $finish;
  end

  // Offer one operand and hold it until the block takes the transfer.
  task automatic send_operand(logic signed [31:0] operand);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= operand;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_operand(operand);
  endtask

  function automatic logic signed [31:0] pick_operand();
    longint unsigned r;
    longint          v;
    logic [31:0]     word;
    case ($urandom_range(0, 9))
      0, 1, 2: word = $urandom;
      3:       word = $urandom_range(0, 1100);
      4:       word = $urandom | 32'h8000_0000;
      5, 6, 7: begin
        // Land on or just around the rounding threshold of a random root.
        r = $urandom_range(1, 46340);
        v = longint'(r * r) + longint'($urandom_range(0, int'(r) + 4)) - 2;
        if (v < 0) v = 0;
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        word = v[31:0];
      end
      8:       word = $urandom >> $urandom_range(0, 31);
      default: word = 32'h7FFF_FFFF - $urandom_range(0, 200000);
    endcase
    return word;
  endfunction

  // Receiver: short random stalls, one long hold-off, none at the end.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_root(out_root);
  end

  initial begin
    logic signed [31:0] edge_operands[$];
    int                 waited;
    edge_operands = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0003,
      32'h0000_0004, 32'h0000_0005, 32'h0000_0008, 32'h0000_000F, 32'h0000_0010,
      32'h0000_0011, 32'h0000_00FF, 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h8000_0001, 32'hFFFF_FFFE, 32'h4000_0000, 32'd2147395600,
      32'd2147441939, 32'd2147441938, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h0000_FFFF, 32'h0001_0000
    };
    quiet        = 1'b0;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (edge_operands[i]) send_operand(edge_operands[i]);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == 300) hold_request = 1'b1;
      if (i == RANDOM_OPS - 200) quiet = 1'b1;
      send_operand(pick_operand());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    sb.flag_leftovers();

    if (sb.errors == 0) begin
      $display("tb_integer_square_root_rounded_top: done, clean");
    end else begin
      $display("tb_integer_square_root_rounded_top: done, errors");
    end
    $finish;
  end

endmodule
